FILE: rtl/core/mwvm_pkg.sv
// package for the mecanum wheel velocity mixer: payload structs, mode and
// register codes, fixed-point constants and helper functions
// no dependencies
`timescale 1ns / 1ps

package mwvm_pkg;

    localparam logic [1:0] MODE_RELAX   = 2'd0;
    localparam logic [1:0] MODE_CHASSIS = 2'd1;
    localparam logic [1:0] MODE_GIMBAL  = 2'd2;

    localparam logic [1:0] CFG_IDX_INSTALL_REVERSED   = 2'd0;
    localparam logic [1:0] CFG_IDX_TURN_RATIO_Q8      = 2'd1;
    localparam logic [1:0] CFG_IDX_SPEED_TO_WHEEL_Q16 = 2'd2;
    localparam logic [1:0] CFG_IDX_GIMBAL_OFFSET_MM   = 2'd3;

    localparam int CFG_DATA_W = 24;

    // pi/2 in Q30, pi/180 in Q24
    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [18:0] DEG_TO_RAD_Q24 = 19'd292818;

    // yaw: two quadrant bits, the rest is the angle within the quadrant
    localparam int YAW_FRAC_W = 14;

    // power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
        logic signed [15:0] turn_rate;
        logic [15:0]        yaw_angle;
    } mwvm_in_t;

    typedef struct packed {
        logic               drive_enable;
        logic signed [23:0] wheel_front_right;
        logic signed [23:0] wheel_front_left;
        logic signed [23:0] wheel_back_left;
        logic signed [23:0] wheel_back_right;
    } mwvm_out_t;

    // classified tick handed from the front to the back
    typedef struct packed {
        logic               drive_enable;
        logic               gimbal_ref;
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
        logic signed [15:0] turn_rate;
        logic signed [15:0] sin_val;
        logic signed [15:0] cos_val;
    } mwvm_cmd_t;

    typedef struct packed {
        logic               install_reversed;
        logic [15:0]        turn_ratio_q8;
        logic [23:0]        speed_to_wheel_q16;
        logic signed [15:0] gimbal_offset_mm;
    } mwvm_cfg_t;

    // one quarter-wave sine entry in Q1.15 from an angle in Q30 (taylor series)
    function automatic logic [15:0] sine_entry(input logic [63:0] ang);
        logic [63:0]        a2;
        logic [63:0]        t;
        logic signed [63:0] sum;
        logic [63:0]        val;
        a2  = (ang * ang) >> 30;
        t   = ang;
        sum = $signed(ang);
        t   = ((t * a2) >> 30) / 6;
        sum = sum - $signed(t);
        t   = ((t * a2) >> 30) / 20;
        sum = sum + $signed(t);
        t   = ((t * a2) >> 30) / 42;
        sum = sum - $signed(t);
        t   = ((t * a2) >> 30) / 72;
        sum = sum + $signed(t);
        t   = ((t * a2) >> 30) / 110;
        sum = sum - $signed(t);
        t   = ((t * a2) >> 30) / 156;
        sum = sum + $signed(t);
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > (64'sd1 <<< 30)) begin
            sum = 64'sd1 <<< 30;
        end
        val = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (val > 64'd32767) begin
            val = 64'd32767;
        end
        return val[15:0];
    endfunction

    // arithmetic shift right, rounding to nearest with halves away from zero
    function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
                                                     input int sh);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = v[63] ? 64'(-v) : 64'(v);
        rnd = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(rnd) : $signed(rnd);
    endfunction

endpackage

FILE: rtl/core/mwvm_front.sv
// front end of the mixer: takes a tick, classifies the mode and looks up
// sine and cosine of the yaw angle in a quarter-wave table
// depends on mwvm_pkg
`timescale 1ns / 1ps

module mwvm_front
    import mwvm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mwvm_in_t  s_data,
    output logic      cmd_valid,
    input  logic      cmd_ready,
    output mwvm_cmd_t cmd_data
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = YAW_FRAC_W + IDX_W;

    logic [15:0] sine_rom [SINE_TABLE_DEPTH + 1];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] ANG = 64'(k) * HALF_PI_Q30 / SINE_TABLE_DEPTH;
        localparam logic [15:0] VAL = sine_entry(ANG);
        assign sine_rom[k] = VAL;
    end

    logic [15:0]        cos_ang;
    logic [PROD_W-1:0]  sin_prod;
    logic [PROD_W-1:0]  cos_prod;
    logic [IDX_W-1:0]   sin_idx;
    logic [IDX_W-1:0]   cos_idx;
    logic [15:0]        sin_mag;
    logic [15:0]        cos_mag;

    logic      valid_reg;
    logic      valid_next;
    mwvm_cmd_t cmd_reg;
    mwvm_cmd_t cmd_next;
    logic      load;

    assign cos_ang = s_data.yaw_angle + 16'd16384;

    always_comb begin
        sin_prod = PROD_W'(s_data.yaw_angle[YAW_FRAC_W-1:0]) * PROD_W'(SINE_TABLE_DEPTH);
        cos_prod = PROD_W'(cos_ang[YAW_FRAC_W-1:0]) * PROD_W'(SINE_TABLE_DEPTH);
        sin_idx  = sin_prod[PROD_W-1:YAW_FRAC_W];
        cos_idx  = cos_prod[PROD_W-1:YAW_FRAC_W];
        // odd quadrants run the table backwards
        if (s_data.yaw_angle[YAW_FRAC_W]) begin
            sin_mag = sine_rom[IDX_W'(SINE_TABLE_DEPTH) - sin_idx];
        end else begin
            sin_mag = sine_rom[sin_idx];
        end
        if (cos_ang[YAW_FRAC_W]) begin
            cos_mag = sine_rom[IDX_W'(SINE_TABLE_DEPTH) - cos_idx];
        end else begin
            cos_mag = sine_rom[cos_idx];
        end
    end

    always_comb begin
        cmd_next.drive_enable = s_data.mode inside {MODE_CHASSIS, MODE_GIMBAL};
        cmd_next.gimbal_ref   = (s_data.mode == MODE_GIMBAL);
        cmd_next.speed_x      = s_data.speed_x;
        cmd_next.speed_y      = s_data.speed_y;
        cmd_next.turn_rate    = s_data.turn_rate;
        cmd_next.sin_val      = s_data.yaw_angle[YAW_FRAC_W+1] ? -$signed(sin_mag)
                                                               : $signed(sin_mag);
        cmd_next.cos_val      = cos_ang[YAW_FRAC_W+1] ? -$signed(cos_mag)
                                                      : $signed(cos_mag);
    end

    assign load       = !valid_reg || cmd_ready;
    assign s_ready    = load;
    assign valid_next = load ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

endmodule

FILE: rtl/core/mwvm_queue.sv
// short queue of classified ticks between the front and the back
// depends on mwvm_pkg
`timescale 1ns / 1ps

module mwvm_queue
    import mwvm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  mwvm_cmd_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output mwvm_cmd_t out_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mwvm_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/core/mwvm_back.sv
// back end of the mixer: rotation, gimbal term, wheel mixing, scaling to
// wheel rate and saturation in a six-stage pipeline with one stall enable
// depends on mwvm_pkg
`timescale 1ns / 1ps

module mwvm_back
    import mwvm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  mwvm_cfg_t cfg,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  mwvm_cmd_t cmd_data,
    output logic      m_valid,
    input  logic      m_ready,
    output mwvm_out_t m_data
);

    localparam int NUM_STG = 6;
    localparam int ROT_W   = 33;   // rotated speed, Q15
    localparam int GP_W    = 52;   // turn_rate * offset * pi/180
    localparam int G_W     = 43;
    localparam int R_W     = 40;
    localparam int CVX_W   = 44;
    localparam int SUM_W   = 45;
    // input ranges keep every wheel sum below 2^40 in Q15
    localparam int Q8_W    = 34;
    localparam int WP_W    = Q8_W + 25;
    localparam int DEG_W   = 36;

    logic               adv;
    logic [NUM_STG-1:0] vld_reg;
    logic [NUM_STG-1:0] vld_next;

    // stage 1: products
    logic               s1_en_reg, s1_gim_reg;
    logic signed [15:0] s1_vx_reg, s1_vy_reg;
    logic signed [31:0] s1_xc_reg, s1_ys_reg, s1_xs_reg, s1_yc_reg, s1_wo_reg;
    logic signed [32:0] s1_wr_reg;
    logic signed [31:0] s1_xc_next, s1_ys_next, s1_xs_next, s1_yc_next, s1_wo_next;
    logic signed [32:0] s1_wr_next;

    // stage 2: rotation and gimbal product
    logic                    s2_en_reg, s2_gim_reg;
    logic signed [ROT_W-1:0] s2_cvx_reg, s2_cvy_reg, s2_cvx_next, s2_cvy_next;
    logic signed [GP_W-1:0]  s2_gp_reg, s2_gp_next;
    logic signed [R_W-1:0]   s2_r_reg, s2_r_next;

    // stage 3: gimbal term applied
    logic                    s3_en_reg;
    logic signed [63:0]      s3_g_full;
    logic signed [G_W-1:0]   s3_g;
    logic signed [CVX_W-1:0] s3_cvx_reg, s3_cvx_next;
    logic signed [ROT_W-1:0] s3_cvy_reg;
    logic signed [R_W-1:0]   s3_r_reg;

    // stage 4: wheel sums in Q8
    logic                    s4_en_reg;
    logic signed [SUM_W-1:0] s4_sum [4];
    logic signed [63:0]      s4_q8_full [4];
    logic signed [Q8_W-1:0]  s4_q8_reg [4];
    logic signed [Q8_W-1:0]  s4_q8_next [4];

    // stage 5: scale to wheel rate
    logic                    s5_en_reg;
    logic signed [WP_W-1:0]  s5_wp_reg [4];
    logic signed [WP_W-1:0]  s5_wp_next [4];

    // output stage
    logic signed [63:0]      o_deg_full [4];
    logic signed [DEG_W-1:0] o_deg [4];
    logic signed [23:0]      o_wheel [4];
    mwvm_out_t               out_reg, out_next;

    assign adv       = !vld_reg[NUM_STG-1] || m_ready;
    assign cmd_ready = adv;
    assign vld_next  = adv ? {vld_reg[NUM_STG-2:0], cmd_valid} : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        s1_xc_next = cmd_data.speed_x * cmd_data.cos_val;
        s1_ys_next = cmd_data.speed_y * cmd_data.sin_val;
        s1_xs_next = cmd_data.speed_x * cmd_data.sin_val;
        s1_yc_next = cmd_data.speed_y * cmd_data.cos_val;
        s1_wo_next = cmd_data.turn_rate * cfg.gimbal_offset_mm;
        s1_wr_next = cmd_data.turn_rate * $signed({1'b0, cfg.turn_ratio_q8});
    end

    always_comb begin
        if (s1_gim_reg) begin
            s2_cvx_next = ROT_W'(s1_xc_reg) - ROT_W'(s1_ys_reg);
            s2_cvy_next = ROT_W'(s1_xs_reg) + ROT_W'(s1_yc_reg);
        end else begin
            s2_cvx_next = ROT_W'(s1_vx_reg) <<< 15;
            s2_cvy_next = ROT_W'(s1_vy_reg) <<< 15;
        end
        s2_gp_next = s1_wo_reg * $signed({1'b0, DEG_TO_RAD_Q24});
        s2_r_next  = R_W'(s1_wr_reg) <<< 7;
    end

    always_comb begin
        s3_g_full   = round_shr(64'(s2_gp_reg), 9);
        s3_g        = s2_gim_reg ? s3_g_full[G_W-1:0] : '0;
        s3_cvx_next = CVX_W'(s2_cvx_reg) - CVX_W'(s3_g);
    end

    always_comb begin
        // wheel order: front right, front left, back left, back right
        s4_sum[0] = SUM_W'(s3_cvx_reg) - SUM_W'(s3_cvy_reg) + SUM_W'(s3_r_reg);
        s4_sum[1] = SUM_W'(s3_cvx_reg) + SUM_W'(s3_cvy_reg) + SUM_W'(s3_r_reg);
        s4_sum[2] = SUM_W'(s3_cvy_reg) - SUM_W'(s3_cvx_reg) + SUM_W'(s3_r_reg);
        s4_sum[3] = SUM_W'(s3_r_reg) - SUM_W'(s3_cvx_reg) - SUM_W'(s3_cvy_reg);
        for (int i = 0; i < 4; i++) begin
            s4_q8_full[i] = round_shr(64'(s4_sum[i]), 7);
            s4_q8_next[i] = s4_q8_full[i][Q8_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            s5_wp_next[i] = s4_q8_reg[i] * $signed({1'b0, cfg.speed_to_wheel_q16});
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_deg_full[i] = round_shr(64'(s5_wp_reg[i]), 24);
            o_deg[i]      = cfg.install_reversed ? -o_deg_full[i][DEG_W-1:0]
                                                 : o_deg_full[i][DEG_W-1:0];
            if (o_deg[i] > DEG_W'(24'sh7FFFFF)) begin
                o_wheel[i] = 24'sh7FFFFF;
            end else if (o_deg[i] < DEG_W'(24'sh800000)) begin
                o_wheel[i] = -24'sh800000;
            end else begin
                o_wheel[i] = o_deg[i][23:0];
            end
            if (!s5_en_reg) begin
                o_wheel[i] = '0;
            end
        end
        out_next.drive_enable      = s5_en_reg;
        out_next.wheel_front_right = o_wheel[0];
        out_next.wheel_front_left  = o_wheel[1];
        out_next.wheel_back_left   = o_wheel[2];
        out_next.wheel_back_right  = o_wheel[3];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_en_reg  <= cmd_data.drive_enable;
            s1_gim_reg <= cmd_data.gimbal_ref;
            s1_vx_reg  <= cmd_data.speed_x;
            s1_vy_reg  <= cmd_data.speed_y;
            s1_xc_reg  <= s1_xc_next;
            s1_ys_reg  <= s1_ys_next;
            s1_xs_reg  <= s1_xs_next;
            s1_yc_reg  <= s1_yc_next;
            s1_wo_reg  <= s1_wo_next;
            s1_wr_reg  <= s1_wr_next;

            s2_en_reg  <= s1_en_reg;
            s2_gim_reg <= s1_gim_reg;
            s2_cvx_reg <= s2_cvx_next;
            s2_cvy_reg <= s2_cvy_next;
            s2_gp_reg  <= s2_gp_next;
            s2_r_reg   <= s2_r_next;

            s3_en_reg  <= s2_en_reg;
            s3_cvx_reg <= s3_cvx_next;
            s3_cvy_reg <= s2_cvy_reg;
            s3_r_reg   <= s2_r_reg;

            s4_en_reg  <= s3_en_reg;
            s4_q8_reg  <= s4_q8_next;

            s5_en_reg  <= s4_en_reg;
            s5_wp_reg  <= s5_wp_next;

            out_reg    <= out_next;
        end
    end

    assign m_valid = vld_reg[NUM_STG-1];
    assign m_data  = out_reg;

endmodule

FILE: rtl/core/mecanum_wheel_velocity_mixer.sv
// Mecanum wheel velocity mixer. Takes one beat per cycle unless held off by
// back-pressure and returns one result beat per input beat, in order, after
// the front register (mode decode and sine/cosine table lookup), the two-entry
// queue and the back pipeline (products, rotation,
// gimbal term, wheel sums, scaling, saturation). The back pipeline stalls as
// a whole when the result is not taken; the queue lets the front keep
// accepting for two more beats. Configuration writes take effect at once and
// belong to idle periods only.
// depends on mwvm_pkg, mwvm_front, mwvm_queue, mwvm_back
`timescale 1ns / 1ps

module mecanum_wheel_velocity_mixer
    import mwvm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mwvm_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mwvm_out_t             m_data
);

    mwvm_cfg_t cfg_reg;
    mwvm_cfg_t cfg_next;
    logic      fq_valid, fq_ready;
    mwvm_cmd_t fq_data;
    logic      qb_valid, qb_ready;
    mwvm_cmd_t qb_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IDX_INSTALL_REVERSED:   cfg_next.install_reversed   = cfg_wdata[0];
                CFG_IDX_TURN_RATIO_Q8:      cfg_next.turn_ratio_q8      = cfg_wdata[15:0];
                CFG_IDX_SPEED_TO_WHEEL_Q16: cfg_next.speed_to_wheel_q16 = cfg_wdata[23:0];
                CFG_IDX_GIMBAL_OFFSET_MM:   cfg_next.gimbal_offset_mm   = cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mwvm_front #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd_data  (fq_data)
    );

    mwvm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    mwvm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd_data  (qb_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: rtl/core/mwvm_checker.sv
// port-level checks for the mecanum wheel velocity mixer, bound to the top
// depends on mwvm_pkg and mecanum_wheel_velocity_mixer
`timescale 1ns / 1ps

module mwvm_checker
    import mwvm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input mwvm_out_t m_data
);

    // a result beat that is not taken holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // the input side is open right after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // disabled drive always carries zero wheel speeds
    a_relax_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.drive_enable |->
            m_data.wheel_front_right == '0 && m_data.wheel_front_left == '0 &&
            m_data.wheel_back_left == '0 && m_data.wheel_back_right == '0)
        else $error("nonzero wheel speed with drive disabled");

endmodule

bind mecanum_wheel_velocity_mixer mwvm_checker u_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

FILE: dv/tb_mecanum_wheel_velocity_mixer.sv
// testbench for the mecanum wheel velocity mixer: directed and random control ticks
// checked against an in-bench fixed-point predictor, with random stalls on both channels
// depends on mwvm_pkg and mecanum_wheel_velocity_mixer
`timescale 1ns / 1ps

module tb_mecanum_wheel_velocity_mixer;
    import mwvm_pkg::*;

    typedef longint unsigned u64_t;

    localparam int         TBL_DEPTH     = 256;
    localparam u64_t       QUARTER_Q30   = 64'd1686629713;
    localparam longint     DEG_RAD_Q24   = 292818;
    localparam longint     SPEED_MAX     = 8388607;
    localparam longint     SPEED_MIN     = -8388608;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         CYCLE_LIMIT   = 500000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    mwvm_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    mwvm_out_t             m_data;

    mecanum_wheel_velocity_mixer #(
        .SINE_TABLE_DEPTH(TBL_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // shadow copy of the block's registers
    logic               cfg_reversed;
    logic [15:0]        cfg_turn_ratio;
    logic [23:0]        cfg_wheel_scale;
    logic signed [15:0] cfg_offset;

    longint    sine_tab [0:TBL_DEPTH];
    mwvm_out_t wheel_expect_q [$];
    mwvm_out_t want;
    int        mismatch_count;
    int        cycle_count;
    bit        src_steady;
    bit        sink_steady;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // quarter-wave table in Q1.15, taylor series on a Q30 angle
    function automatic void build_sine();
        u64_t   a;
        u64_t   a2;
        u64_t   t;
        u64_t   val;
        longint sum;
        for (u64_t k = 0; k <= TBL_DEPTH; k++) begin
            a   = k * QUARTER_Q30 / TBL_DEPTH;
            a2  = (a * a) >> 30;
            t   = a;
            sum = longint'(a);
            for (u64_t n = 1; n <= 6; n++) begin
                t = ((t * a2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n[0]) begin
                    sum = sum - longint'(t);
                end else begin
                    sum = sum + longint'(t);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > (longint'(1) << 30)) begin
                sum = longint'(1) << 30;
            end
            val = (u64_t'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (val > 64'd32767) begin
                val = 64'd32767;
            end
            sine_tab[k] = longint'(val);
        end
    endfunction

    function automatic longint sine_at(logic [15:0] ang);
        u64_t   idx;
        longint v;
        idx = (u64_t'(ang[13:0]) * TBL_DEPTH) >> 14;
        if (idx > TBL_DEPTH) begin
            idx = TBL_DEPTH;
        end
        v = ang[14] ? sine_tab[TBL_DEPTH - idx] : sine_tab[idx];
        return ang[15] ? -v : v;
    endfunction

    // round to nearest, halves away from zero
    function automatic longint round_away(longint v, int sh);
        u64_t mag;
        mag = (v < 0) ? u64_t'(-v) : u64_t'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [23:0] wheel_speed(longint sum_q15);
        longint q8;
        longint deg;
        q8  = round_away(sum_q15, 7);
        deg = round_away(q8 * longint'(cfg_wheel_scale), 24);
        if (cfg_reversed) begin
            deg = -deg;
        end
        if (deg > SPEED_MAX) begin
            deg = SPEED_MAX;
        end
        if (deg < SPEED_MIN) begin
            deg = SPEED_MIN;
        end
        return deg[23:0];
    endfunction

    function automatic mwvm_out_t mix_wheels(mwvm_in_t t);
        longint      vx;
        longint      vy;
        longint      w;
        longint      s;
        longint      c;
        longint      g;
        longint      cvx;
        longint      cvy;
        longint      r;
        logic [15:0] c_ang;
        mwvm_out_t   o;
        o = '0;
        if (t.mode != MODE_CHASSIS && t.mode != MODE_GIMBAL) begin
            return o;
        end
        vx = t.speed_x;
        vy = t.speed_y;
        w  = t.turn_rate;
        if (t.mode == MODE_CHASSIS) begin
            cvx = vx * 32768;
            cvy = vy * 32768;
        end else begin
            c_ang = t.yaw_angle + 16'h4000;
            s     = sine_at(t.yaw_angle);
            c     = sine_at(c_ang);
            g     = round_away(w * longint'(cfg_offset) * DEG_RAD_Q24, 9);
            cvx   = vx * c - vy * s - g;
            cvy   = vx * s + vy * c;
        end
        r = w * longint'(cfg_turn_ratio) * 128;
        o.drive_enable      = 1'b1;
        o.wheel_front_right = wheel_speed(cvx - cvy + r);
        o.wheel_front_left  = wheel_speed(cvx + cvy + r);
        o.wheel_back_left   = wheel_speed(-cvx + cvy + r);
        o.wheel_back_right  = wheel_speed(-cvx - cvy + r);
        return o;
    endfunction

    function automatic mwvm_in_t make_tick(logic [1:0] mode, logic [15:0] vx, logic [15:0] vy,
                                           logic [15:0] w, logic [15:0] yaw);
        mwvm_in_t t;
        t.mode      = mode;
        t.speed_x   = vx;
        t.speed_y   = vy;
        t.turn_rate = w;
        t.yaw_angle = yaw;
        return t;
    endfunction

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 400)) - 16'd200;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_yaw();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 3)) << 14;
            1:       return (16'($urandom_range(0, 3)) << 14) | 16'h3FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_mode();
        case ($urandom_range(0, 9))
            0:          return MODE_RELAX;
            1:          return MODE_UNUSED;
            2, 3, 4, 5: return MODE_CHASSIS;
            default:    return MODE_GIMBAL;
        endcase
    endfunction

    task automatic check_field(string what, logic [23:0] exp_v, logic [23:0] got_v);
        if (exp_v !== got_v) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch on %s: expected %h, got %h", what, exp_v, got_v);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (wheel_expect_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result beat with nothing expected: %h", m_data);
                end
            end else begin
                want = wheel_expect_q.pop_front();
                check_field("drive_enable", {23'b0, want.drive_enable},
                            {23'b0, m_data.drive_enable});
                check_field("wheel_front_right", want.wheel_front_right,
                            m_data.wheel_front_right);
                check_field("wheel_front_left", want.wheel_front_left,
                            m_data.wheel_front_left);
                check_field("wheel_back_left", want.wheel_back_left, m_data.wheel_back_left);
                check_field("wheel_back_right", want.wheel_back_right,
                            m_data.wheel_back_right);
            end
        end
    end

    // result side: random stall before taking each beat
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = sink_steady ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_tick(mwvm_in_t t);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        wheel_expect_q.push_back(mix_wheels(t));
        @(negedge aclk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_IDX_INSTALL_REVERSED:   cfg_reversed    = data[0];
            CFG_IDX_TURN_RATIO_Q8:      cfg_turn_ratio  = data[15:0];
            CFG_IDX_SPEED_TO_WHEEL_Q16: cfg_wheel_scale = data[23:0];
            CFG_IDX_GIMBAL_OFFSET_MM:   cfg_offset      = data[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (wheel_expect_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // registers still at reset: zero scale, so only drive_enable moves
    task automatic test_reset_defaults();
        send_tick(make_tick(MODE_CHASSIS, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000));
        send_tick(make_tick(MODE_GIMBAL, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF));
        send_tick(make_tick(MODE_RELAX, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
        send_tick(make_tick(MODE_GIMBAL, 16'h0000, 16'h0000, 16'h0000, 16'h4000));
        settle();
    endtask

    task automatic test_modes_directed();
        write_register(CFG_IDX_INSTALL_REVERSED, 24'h0);
        write_register(CFG_IDX_TURN_RATIO_Q8, 24'h000180);
        write_register(CFG_IDX_SPEED_TO_WHEEL_Q16, 24'h010000);
        write_register(CFG_IDX_GIMBAL_OFFSET_MM, 24'd120);
        // relax and the undefined mode both disable the drive
        send_tick(make_tick(MODE_RELAX, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        send_tick(make_tick(MODE_UNUSED, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_tick(make_tick(MODE_CHASSIS, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_tick(make_tick(MODE_CHASSIS, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000));
        send_tick(make_tick(MODE_CHASSIS, 16'h8000, 16'h0000, 16'h0000, 16'h0000));
        send_tick(make_tick(MODE_CHASSIS, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000));
        send_tick(make_tick(MODE_CHASSIS, 16'h0000, 16'h0000, 16'h8000, 16'h0000));
        send_tick(make_tick(MODE_CHASSIS, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000));
        send_tick(make_tick(MODE_CHASSIS, 16'h0001, 16'hFFFF, 16'h0001, 16'h0000));
        // gimbal mode at each quadrant boundary and inside the first
        send_tick(make_tick(MODE_GIMBAL, 16'd1000, -16'sd500, 16'd90, 16'h0000));
        send_tick(make_tick(MODE_GIMBAL, 16'd1000, -16'sd500, 16'd90, 16'h4000));
        send_tick(make_tick(MODE_GIMBAL, 16'd1000, -16'sd500, 16'd90, 16'h8000));
        send_tick(make_tick(MODE_GIMBAL, 16'd1000, -16'sd500, 16'd90, 16'hC000));
        send_tick(make_tick(MODE_GIMBAL, 16'd1000, -16'sd500, 16'd90, 16'hFFFF));
        send_tick(make_tick(MODE_GIMBAL, 16'd1000, -16'sd500, 16'd90, 16'h1FFF));
        send_tick(make_tick(MODE_GIMBAL, 16'h7FFF, 16'h8000, 16'h8000, 16'h3FFF));
        settle();
    endtask

    task automatic test_saturation();
        write_register(CFG_IDX_INSTALL_REVERSED, 24'hFFFFFF);
        write_register(CFG_IDX_TURN_RATIO_Q8, 24'hFFFFFF);
        write_register(CFG_IDX_SPEED_TO_WHEEL_Q16, 24'hFFFFFF);
        write_register(CFG_IDX_GIMBAL_OFFSET_MM, 24'h008000);
        send_tick(make_tick(MODE_CHASSIS, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000));
        send_tick(make_tick(MODE_CHASSIS, 16'h8000, 16'h8000, 16'h8000, 16'h0000));
        send_tick(make_tick(MODE_CHASSIS, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000));
        send_tick(make_tick(MODE_GIMBAL, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h2000));
        send_tick(make_tick(MODE_RELAX, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h2000));
        settle();
        write_register(CFG_IDX_INSTALL_REVERSED, 24'h0);
        send_tick(make_tick(MODE_CHASSIS, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000));
        send_tick(make_tick(MODE_GIMBAL, 16'h8000, 16'h8000, 16'h8000, 16'hA000));
        settle();
    endtask

    task automatic test_random_settings();
        logic [CFG_DATA_W-1:0] junk;
        for (int p = 0; p < 8; p++) begin
            junk = CFG_DATA_W'($urandom);
            case (p)
                0: begin
                    write_register(CFG_IDX_INSTALL_REVERSED, {junk[23:1], 1'b0});
                    write_register(CFG_IDX_TURN_RATIO_Q8, {junk[23:16], 16'h0000});
                    write_register(CFG_IDX_SPEED_TO_WHEEL_Q16, 24'h010000);
                    write_register(CFG_IDX_GIMBAL_OFFSET_MM, {junk[23:16], 16'h0000});
                end
                1: begin
                    write_register(CFG_IDX_INSTALL_REVERSED, {junk[23:1], 1'b1});
                    write_register(CFG_IDX_TURN_RATIO_Q8, {junk[23:16], 16'hFFFF});
                    write_register(CFG_IDX_SPEED_TO_WHEEL_Q16, 24'hFFFFFF);
                    write_register(CFG_IDX_GIMBAL_OFFSET_MM, {junk[23:16], 16'h7FFF});
                end
                2: begin
                    write_register(CFG_IDX_INSTALL_REVERSED, 24'h0);
                    write_register(CFG_IDX_TURN_RATIO_Q8, 24'($urandom));
                    write_register(CFG_IDX_SPEED_TO_WHEEL_Q16, 24'($urandom_range(0, 24'h3FFFF)));
                    write_register(CFG_IDX_GIMBAL_OFFSET_MM, {junk[23:16], 16'h8000});
                end
                default: begin
                    write_register(CFG_IDX_INSTALL_REVERSED, 24'($urandom));
                    write_register(CFG_IDX_TURN_RATIO_Q8, 24'($urandom));
                    if ($urandom_range(0, 1)) begin
                        write_register(CFG_IDX_SPEED_TO_WHEEL_Q16,
                                       24'($urandom_range(0, 24'h3FFFF)));
                    end else begin
                        write_register(CFG_IDX_SPEED_TO_WHEEL_Q16, 24'($urandom));
                    end
                    write_register(CFG_IDX_GIMBAL_OFFSET_MM, 24'($urandom));
                end
            endcase
            for (int n = 0; n < 80; n++) begin
                // stretches where one side or both never idle
                if (n % 20 == 0) begin
                    src_steady  = ($urandom_range(0, 3) == 0);
                    sink_steady = ($urandom_range(0, 3) == 0);
                end
                send_tick(make_tick(pick_mode(), pick_speed(), pick_speed(), pick_speed(),
                                    pick_yaw()));
            end
            settle();
            src_steady  = 1'b0;
            sink_steady = 1'b0;
        end
    endtask

    initial begin
        cycle_count     = 0;
        mismatch_count  = 0;
        src_steady      = 1'b0;
        sink_steady     = 1'b0;
        cfg_reversed    = 1'b0;
        cfg_turn_ratio  = '0;
        cfg_wheel_scale = '0;
        cfg_offset      = '0;
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_IDX_INSTALL_REVERSED;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_data          = '0;
        build_sine();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_modes_directed();
        test_saturation();
        test_random_settings();

        if (mismatch_count == 0 && wheel_expect_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
